[sv/mst_pkg.sv]
// Shared types, codes and defaults for the minimum spanning tree core.
package mst_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int WEIGHT_BITS_DEF  = 16;
   localparam int TOTAL_BITS       = 21;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_START_VERTEX = 1'b1;

   typedef struct packed {
      logic        command;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [15:0] weight;
      logic        no_edge;
   } req_type;

   typedef struct packed {
      logic                  is_edge;
      logic [4:0]            edge_vertex;
      logic [4:0]            edge_partner;
      logic [TOTAL_BITS-1:0] total_cost;
      logic [4:0]            edge_count;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic load_en;
      logic run_start;
      logic pass_start;
      logic emit_edge;
      logic emit_sum;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic found;
      logic rounds_done;
      logic out_free;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PASS   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_SUM    = 4'b1000
   } state_type;

endpackage

[sv/mst_ctrl.sv]
// Sequencer for loads, scan passes, edge emission and the run summary.
module mst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_command,
   output logic                req_stall,
   input  mst_pkg::status_type stat,
   output mst_pkg::cmd_type    cmd
);

   mst_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         mst_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_command == mst_pkg::CMD_RUN) begin
                  cmd.run_start = 1'b1;
                  state_in      = mst_pkg::ST_PASS;
               end else begin
                  cmd.load_en = 1'b1;
               end
            end
         end
         mst_pkg::ST_PASS: begin
            if (stat.pass_done) begin
               state_in = mst_pkg::ST_DECIDE;
            end
         end
         mst_pkg::ST_DECIDE: begin
            if (stat.rounds_done || !stat.found) begin
               state_in = mst_pkg::ST_SUM;
            end else if (stat.out_free) begin
               cmd.emit_edge  = 1'b1;
               cmd.pass_start = 1'b1;
               state_in       = mst_pkg::ST_PASS;
            end
         end
         mst_pkg::ST_SUM: begin
            if (stat.out_free) begin
               cmd.emit_sum = 1'b1;
               state_in     = mst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/mst_datapath.sv]
// Weight memory, per-vertex link table, scan pipeline, totals and result register.
module mst_datapath #(
   parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  mst_pkg::cmd_type    cmd,
   output mst_pkg::status_type stat,
   input  mst_pkg::req_type    req_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [5:0]          csr_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output mst_pkg::rsp_type    rsp_data
);

   localparam int NMAX  = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
   localparam int VB    = $clog2(MAX_VERTICES);
   localparam int NW    = $clog2(NMAX + 1);
   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int WB    = WEIGHT_BITS;
   localparam int TB    = mst_pkg::TOTAL_BITS;
   localparam int SUMW  = ((WB > TB) ? WB : TB) + 1;
   localparam logic [AW-1:0] ROW_STEP = AW'(MAX_VERTICES);

   logic [WB:0]    mem [DEPTH];
   logic [WB:0]    rd_data_ff;

   logic [5:0]     vertex_count_ff;
   logic [4:0]     start_vertex_ff;

   logic [NW-1:0]  n_ff;
   logic [VB-1:0]  ref_ff;
   logic           first_ff;
   logic           in_tree_ff [MAX_VERTICES];
   logic [VB-1:0]  link_ff [MAX_VERTICES];
   logic [WB:0]    lw_ff [MAX_VERTICES];

   logic           iss_active_ff;
   logic [VB-1:0]  iss_idx_ff;
   logic           pv_ff;
   logic [VB-1:0]  pidx_ff;

   logic           found_ff;
   logic [VB-1:0]  best_ff;
   logic [WB-1:0]  bw_ff;
   logic [TB-1:0]  cost_ff;
   logic [4:0]     chosen_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   mst_pkg::rsp_type rsp_data_ff;

   logic [6:0]     n_sel;
   logic [NW-1:0]  n_in;
   logic [VB-1:0]  s_in;
   logic [VB-1:0]  last_idx;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;
   logic           wr_range;
   logic [WB:0]    cur_w;
   logic [WB:0]    new_w;
   logic           heavy;
   logic           upd;
   logic           better;
   logic [SUMW-1:0] sum_w;
   logic [TB-1:0]  cost_sat;
   logic [4:0]     chosen_inc;
   logic           out_free;

   // run setup
   always_comb begin
      if (vertex_count_ff == 6'd0) begin
         n_sel = 7'd1;
      end else if (7'(vertex_count_ff) > 7'(NMAX)) begin
         n_sel = 7'(NMAX);
      end else begin
         n_sel = 7'(vertex_count_ff);
      end
      n_in = NW'(n_sel);
      s_in = (7'(start_vertex_ff) >= n_sel) ? '0 : VB'(start_vertex_ff);
   end

   assign last_idx = VB'(n_ff - NW'(1));
   assign wr_range = (32'(req_data.row) < MAX_VERTICES) && (32'(req_data.col) < MAX_VERTICES);
   assign wr_addr  = AW'(AW'(req_data.row) * ROW_STEP + AW'(req_data.col));
   assign rd_addr  = AW'(AW'(iss_idx_ff) * ROW_STEP + AW'(ref_ff));

   // scan element compare
   always_comb begin
      cur_w = lw_ff[pidx_ff];
      if (cur_w[WB]) begin
         heavy = !rd_data_ff[WB];
      end else begin
         heavy = !rd_data_ff[WB] && (cur_w[WB-1:0] > rd_data_ff[WB-1:0]);
      end
      upd    = first_ff || (!in_tree_ff[pidx_ff] && heavy);
      new_w  = upd ? rd_data_ff : cur_w;
      better = !in_tree_ff[pidx_ff] && !new_w[WB] &&
               (!found_ff || (new_w[WB-1:0] < bw_ff));
   end

   always_comb begin
      sum_w      = SUMW'(cost_ff) + SUMW'(bw_ff);
      cost_sat   = (sum_w > SUMW'(mst_pkg::TOTAL_MAX)) ? mst_pkg::TOTAL_MAX : TB'(sum_w);
      chosen_inc = chosen_ff + 5'd1;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.emit_edge || cmd.emit_sum) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      stat.pass_done   = pv_ff && (pidx_ff == last_idx);
      stat.found       = found_ff;
      stat.rounds_done = (7'(chosen_ff) == 7'(n_ff) - 7'd1);
      stat.out_free    = out_free;
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (cmd.load_en && wr_range) begin
         mem[wr_addr] <= {req_data.no_edge, WB'(req_data.weight)};
      end
      if (iss_active_ff) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= 6'd32;
         start_vertex_ff <= 5'd0;
         iss_active_ff   <= 1'b0;
         pv_ff           <= 1'b0;
         cost_ff         <= '0;
         chosen_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               mst_pkg::CSR_VERTEX_COUNT: vertex_count_ff <= csr_data;
               mst_pkg::CSR_START_VERTEX: start_vertex_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (cmd.run_start || cmd.pass_start) begin
            iss_active_ff <= 1'b1;
         end else if (iss_active_ff && (iss_idx_ff == last_idx)) begin
            iss_active_ff <= 1'b0;
         end
         pv_ff <= iss_active_ff;
         if (cmd.run_start) begin
            cost_ff   <= '0;
            chosen_ff <= '0;
         end else if (cmd.emit_edge) begin
            cost_ff   <= cost_sat;
            chosen_ff <= chosen_inc;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan state and link table
   always_ff @(posedge clock) begin
      pidx_ff <= iss_idx_ff;
      if (cmd.run_start || cmd.pass_start) begin
         iss_idx_ff <= '0;
      end else if (iss_active_ff) begin
         iss_idx_ff <= iss_idx_ff + VB'(1);
      end
      if (cmd.run_start) begin
         n_ff     <= n_in;
         ref_ff   <= s_in;
         first_ff <= 1'b1;
         found_ff <= 1'b0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            in_tree_ff[i] <= (VB'(i) == s_in);
            link_ff[i]    <= s_in;
         end
      end else if (cmd.pass_start) begin
         ref_ff                <= best_ff;
         first_ff              <= 1'b0;
         found_ff              <= 1'b0;
         in_tree_ff[best_ff]   <= 1'b1;
      end else if (pv_ff) begin
         if (upd) begin
            lw_ff[pidx_ff]   <= rd_data_ff;
            link_ff[pidx_ff] <= ref_ff;
         end
         if (better) begin
            found_ff <= 1'b1;
            best_ff  <= pidx_ff;
            bw_ff    <= new_w[WB-1:0];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit_edge) begin
         rsp_data_ff.is_edge      <= 1'b1;
         rsp_data_ff.edge_vertex  <= 5'(best_ff);
         rsp_data_ff.edge_partner <= 5'(link_ff[best_ff]);
         rsp_data_ff.total_cost   <= cost_sat;
         rsp_data_ff.edge_count   <= chosen_inc;
         rsp_data_ff.last         <= 1'b0;
      end else if (cmd.emit_sum) begin
         rsp_data_ff.is_edge      <= 1'b0;
         rsp_data_ff.edge_vertex  <= '0;
         rsp_data_ff.edge_partner <= '0;
         rsp_data_ff.total_cost   <= cost_ff;
         rsp_data_ff.edge_count   <= chosen_ff;
         rsp_data_ff.last         <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/prim_minimum_spanning_tree_core.sv]
// Top level of the dense Prim minimum spanning tree core.
// A load transfer writes one weight-matrix entry; loads stream back to
// back. A run transfer grows the tree from start_vertex (zero if not below
// n) over n vertices, n being vertex_count with zero taken as one and
// larger counts clamped to MAX_VERTICES or 32, whichever is less: every
// round is one scan of n matrix entries through the single read port of the
// weight memory, one entry per cycle, into a registered read and then the
// compare and link update; a decision state follows, which waits while the
// result side stalls. The scan also relinks the outside vertices, so each
// round emits its edge before the next scan starts. Results: one edge
// transfer per chosen edge, then one summary transfer with last set. No new
// transfer is taken until the summary is in the result register. Matrix
// entries never loaded read back as unknown.
module prim_minimum_spanning_tree_core #(
   parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mst_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [5:0]       csr_data
);

   mst_pkg::cmd_type    cmd;
   mst_pkg::status_type stat;

   assign csr_ready = 1'b1;

   mst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   mst_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_en, cmd.run_start, cmd.emit_edge, cmd.emit_sum}))
      else $error("controller issued conflicting commands");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_edge || cmd.emit_sum) |-> stat.out_free)
      else $error("result overwritten while stalled");

   a_last_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> !rsp_data.is_edge)
      else $error("summary transfer flagged as edge");

   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_edge) |-> (rsp_data.edge_count != 5'd0))
      else $error("edge transfer with zero edge count");
`endif

endmodule

[test/tb_prim_minimum_spanning_tree_core.sv]
// Testbench for the dense Prim spanning tree core: scoreboard, drivers and checks.
`timescale 1ns / 1ps

class span_tree_board;
   localparam int VMAX = mst_pkg::MAX_VERTICES_DEF;

   bit [15:0]        weights [VMAX*VMAX];
   bit               absent  [VMAX*VMAX];
   bit               loaded  [VMAX*VMAX];
   bit [5:0]         vcount_reg;
   bit [4:0]         start_reg;
   mst_pkg::rsp_type expected_edges [$];
   int               errors;
   int               checked;
   int               loads;
   int               runs;

   function new();
      vcount_reg = 6'd32;
      start_reg  = 5'd0;
   endfunction

   function void set_reg(logic index, bit [5:0] value);
      if (index == mst_pkg::CSR_VERTEX_COUNT) begin
         vcount_reg = value;
      end else begin
         start_reg = value[4:0];
      end
   endfunction

   function int span();
      int n;
      n = vcount_reg;
      if (n == 0) n = 1;
      if (n > VMAX) n = VMAX;
      return n;
   endfunction

   function int pending();
      return expected_edges.size();
   endfunction

   function bit heavier(int r, int c, int d);
      int a;
      int b;
      a = r * VMAX + c;
      b = r * VMAX + d;
      if (absent[a]) return !absent[b];
      if (absent[b]) return 1'b0;
      return weights[a] > weights[b];
   endfunction

   function void grow_tree();
      int               n;
      int               s;
      int               best;
      int               bw;
      int               idx;
      int               total;
      int               chosen;
      bit               found;
      int               link    [VMAX];
      bit               in_tree [VMAX];
      mst_pkg::rsp_type r;
      n = span();
      s = start_reg;
      if (s >= n) s = 0;
      for (int i = 0; i < n; i++) begin
         link[i]    = s;
         in_tree[i] = (i == s);
      end
      total  = 0;
      chosen = 0;
      for (int round = 0; round + 1 < n; round++) begin
         found = 1'b0;
         best  = 0;
         bw    = 0;
         for (int i = 0; i < n; i++) begin
            idx = i * VMAX + link[i];
            if (in_tree[i] || absent[idx]) continue;
            if (!found || weights[idx] < bw) begin
               found = 1'b1;
               bw    = weights[idx];
               best  = i;
            end
         end
         if (!found) continue;
         total = total + bw;
         if (total > mst_pkg::TOTAL_MAX) total = mst_pkg::TOTAL_MAX;
         chosen = (chosen + 1) % 32;
         r              = '0;
         r.is_edge      = 1'b1;
         r.edge_vertex  = best[4:0];
         r.edge_partner = link[best][4:0];
         r.total_cost   = total[20:0];
         r.edge_count   = chosen[4:0];
         expected_edges.push_back(r);
         in_tree[best] = 1'b1;
         for (int k = 0; k < n; k++) begin
            if (!in_tree[k] && heavier(k, link[k], best)) link[k] = best;
         end
      end
      r            = '0;
      r.total_cost = total[20:0];
      r.edge_count = chosen[4:0];
      r.last       = 1'b1;
      expected_edges.push_back(r);
   endfunction

   function void note_transfer(mst_pkg::req_type item);
      int idx;
      if (item.command == mst_pkg::CMD_LOAD) begin
         idx          = item.row * VMAX + item.col;
         weights[idx] = item.weight;
         absent[idx]  = item.no_edge;
         loaded[idx]  = 1'b1;
         loads++;
      end else begin
         runs++;
         grow_tree();
      end
   endfunction

   function void field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function void check_result(mst_pkg::rsp_type got);
      mst_pkg::rsp_type want;
      if (expected_edges.size() == 0) begin
         errors++;
         $display("%0t: result %h with nothing expected", $time, got);
         return;
      end
      want = expected_edges.pop_front();
      checked++;
      field_diff("is_edge", want.is_edge, got.is_edge);
      field_diff("edge_vertex", want.edge_vertex, got.edge_vertex);
      field_diff("edge_partner", want.edge_partner, got.edge_partner);
      field_diff("total_cost", want.total_cost, got.total_cost);
      field_diff("edge_count", want.edge_count, got.edge_count);
      field_diff("last", want.last, got.last);
   endfunction
endclass

module tb_prim_minimum_spanning_tree_core;

   localparam int HALF_PERIOD = 10;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 12;
   localparam int VMAX        = mst_pkg::MAX_VERTICES_DEF;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mst_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mst_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = mst_pkg::CSR_VERTEX_COUNT;
   logic [5:0]       csr_data  = '0;

   bit req_burst;
   bit rsp_burst;
   bit sparse;
   int hold_ask;
   int hold_done;

   span_tree_board sb = new();

   prim_minimum_spanning_tree_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp_data);
   end

   initial begin : rsp_side
      int w;
      forever begin
         if (hold_ask != hold_done) begin
            w = LONG_HOLD;
            hold_done++;
         end else begin
            w = rsp_burst ? 0 : $urandom_range(0, 13);
         end
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   initial begin : watchdog
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_req(input mst_pkg::req_type item);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_transfer(item);
   endtask

   task automatic send_entry(input int r, input int c, input int w, input bit ne);
      mst_pkg::req_type item;
      item         = '0;
      item.command = mst_pkg::CMD_LOAD;
      item.row     = r[4:0];
      item.col     = c[4:0];
      item.weight  = w[15:0];
      item.no_edge = ne;
      send_req(item);
   endtask

   task automatic send_random_load(input int r, input int c);
      int k;
      int w;
      k = $urandom_range(0, 9);
      if (k == 0) w = 0;
      else if (k == 1) w = 16'hFFFF;
      else if (k < 5) w = $urandom_range(0, 7);
      else w = $urandom_range(0, 16'hFFFF);
      send_entry(r, c, w, $urandom_range(0, sparse ? 2 : 7) == 0);
   endtask

   task automatic send_run();
      mst_pkg::req_type item;
      item         = '0;
      item.command = mst_pkg::CMD_RUN;
      item.row     = 5'($urandom_range(0, 31));
      item.col     = 5'($urandom_range(0, 31));
      item.weight  = 16'($urandom_range(0, 16'hFFFF));
      item.no_edge = 1'($urandom_range(0, 1));
      send_req(item);
   endtask

   task automatic write_csr(input logic index, input logic [5:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.set_reg(index, value);
      @(posedge clock);
   endtask

   // hold off until the last result is out and any load has settled
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input int vc, input int sv);
      if ($urandom_range(0, 1)) begin
         write_csr(mst_pkg::CSR_VERTEX_COUNT, vc[5:0]);
         write_csr(mst_pkg::CSR_START_VERTEX, sv[5:0]);
      end else begin
         write_csr(mst_pkg::CSR_START_VERTEX, sv[5:0]);
         write_csr(mst_pkg::CSR_VERTEX_COUNT, vc[5:0]);
      end
   endtask

   task automatic fill_matrix(input int n);
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            if (!sb.loaded[r * VMAX + c]) send_random_load(r, c);
         end
      end
   endtask

   // column s reaches only vertex b, column b reaches nothing
   task automatic load_two_columns(input int s, input int b);
      for (int r = 0; r < VMAX; r++) begin
         send_entry(r, s, $urandom_range(0, 16'hFFFF), r != b);
      end
      for (int r = 0; r < VMAX; r++) begin
         send_entry(r, b, $urandom_range(0, 16'hFFFF), 1'b1);
      end
   endtask

   task automatic mixed_traffic(input int n, input int count);
      int k;
      repeat (count) begin
         k = $urandom_range(0, 9);
         if (k < 2) begin
            send_run();
            if ($urandom_range(0, 5) == 0) wait_drained();
         end else if (k < 8) begin
            send_random_load($urandom_range(0, n - 1), $urandom_range(0, n - 1));
         end else begin
            send_random_load($urandom_range(0, VMAX - 1), $urandom_range(0, VMAX - 1));
         end
      end
      send_run();
   endtask

   initial begin : stimulus
      int vc;
      int sv;
      int n;
      int hub;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // three vertices, one unreachable, then a tie and a strict relink
      write_csr(mst_pkg::CSR_VERTEX_COUNT, 6'd3);
      write_csr(mst_pkg::CSR_START_VERTEX, 6'd1);
      send_entry(0, 0, 5, 1'b0);
      send_entry(0, 1, 16'hFFFF, 1'b0);
      send_entry(0, 2, 0, 1'b0);
      send_entry(1, 0, 0, 1'b0);
      send_entry(1, 1, 0, 1'b0);
      send_entry(1, 2, 7, 1'b0);
      send_entry(2, 0, 16'hFFFF, 1'b1);
      send_entry(2, 1, 0, 1'b1);
      send_entry(2, 2, 16'hFFFF, 1'b1);
      send_run();
      send_entry(2, 1, 16'hFFFF, 1'b0);
      send_entry(2, 0, 16'hFFFF, 1'b0);
      send_run();
      send_entry(2, 0, 3, 1'b0);
      send_run();
      wait_drained();
      write_csr(mst_pkg::CSR_VERTEX_COUNT, 6'd0);
      write_csr(mst_pkg::CSR_START_VERTEX, 6'h3F);
      send_run();

      for (int ph = 0; ph < 10; ph++) begin
         wait_drained();
         if (ph == 0) vc = 2;
         else if (ph == 1) vc = 1;
         else vc = $urandom_range(1, 8);
         sv = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, vc - 1);
         configure(vc, sv);
         req_burst = $urandom_range(0, 3) == 0;
         rsp_burst = $urandom_range(0, 3) == 0;
         sparse    = $urandom_range(0, 2) == 0;
         n = sb.span();
         fill_matrix(n);
         if (ph == 3) begin
            hold_ask++;
            repeat (3) send_run();
         end
         mixed_traffic(n, 11);
      end

      // largest vertex counts over two loaded columns
      wait_drained();
      sv  = $urandom_range(0, VMAX - 1);
      hub = (sv + 1 + $urandom_range(0, VMAX - 2)) % VMAX;
      req_burst = 1'b1;
      rsp_burst = 1'b0;
      load_two_columns(sv, hub);
      req_burst = 1'b0;
      wait_drained();
      configure(32, sv);
      send_run();
      wait_drained();
      configure(6'h3F, sv);
      send_run();
      wait_drained();
      configure($urandom_range(33, 62), 6'h20 | sv);
      send_run();
      wait_drained();

      $display("Covered %0d weight loads and %0d tree runs, vertex counts 0 to 63 written,",
               sb.loads, sb.runs);
      $display("%0d results compared under random idling, a long output hold and backpressure.",
               sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
